[hdl/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 32;
  localparam int COST_W   = 16;
  localparam int TAG_W    = 2;
  localparam int INDEX_W  = 8;
  localparam int WORD_W   = 4;
  localparam int LINES    = 256;
  localparam int LWORDS   = 4096;
  localparam int STEP_W   = 5;
  localparam int KIND_W   = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] REG_CACHE_READ  = 2'd0;
  localparam logic [1:0] REG_CACHE_WRITE = 2'd1;
  localparam logic [1:0] REG_MEM_READ    = 2'd2;
  localparam logic [1:0] REG_MEM_WRITE   = 2'd3;

  localparam logic [COST_W-1:0] RST_CACHE_READ  = 16'd1;
  localparam logic [COST_W-1:0] RST_CACHE_WRITE = 16'd1;
  localparam logic [COST_W-1:0] RST_MEM_READ    = 16'd100;
  localparam logic [COST_W-1:0] RST_MEM_WRITE   = 16'd50;

  localparam logic [STEP_W-1:0] STEP_LAST = 5'd16;

  typedef struct packed {
    logic [COST_W-1:0] cache_read;
    logic [COST_W-1:0] cache_write;
    logic [COST_W-1:0] mem_read;
    logic [COST_W-1:0] mem_write;
  } dmc_cost_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic miss;
    logic wb_step;
    logic fill_step;
    logic finish;
  } dmc_cmd_t;

  typedef struct packed {
    logic is_access;
    logic hit;
    logic victim_dirty;
    logic step_last;
    logic clear_last;
    logic out_free;
  } dmc_status_t;

endpackage

[hdl/direct_mapped_writeback_cache_top.sv]
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_top
// Direct-mapped write-back, write-allocate cache, 256 lines of 64 bytes, in
// front of an on-chip backing memory, with a wrapping access cost counter.
//
//   channel   handshake             payload
//   --------  --------------------  ---------------------------------------
//   in        in_valid / in_ready   kind, address, write_data
//   out       out_valid / out_ready read_data, hit, wrote_back, elapsed_time
//   config    APB psel/penable      paddr, pwdata, prdata (pready tied high)
//
// Hit, clear or unused kind: accept, then lookup, which completes it.
// Clean miss: accept, lookup, block fill through the backing memory port, completion.
// Dirty miss: accept, lookup, write-back of the victim block, the fill, completion.
// After reset all 2^(MEMORY_ADDRESS_BITS-2) backing memory words (16384 by
// default) are zeroed, with in_ready low; config writes are taken throughout.
// A stalled output holds the next transaction at the lookup or final step.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_top #(
  parameter int MEMORY_ADDRESS_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dmc_pkg::KIND_W-1:0]   kind,
  input  logic [dmc_pkg::ADDR_W-1:0]   address,
  input  logic [dmc_pkg::DATA_W-1:0]   write_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dmc_pkg::DATA_W-1:0]   read_data,
  output logic                         hit,
  output logic                         wrote_back,
  output logic [dmc_pkg::DATA_W-1:0]   elapsed_time,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dmc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dmc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  dmc_pkg::dmc_cost_t   cost;
  dmc_pkg::dmc_cmd_t    cmd;
  dmc_pkg::dmc_status_t st;

  dmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cost    (cost)
  );

  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  dmc_dp #(
    .MEMORY_ADDRESS_BITS (MEMORY_ADDRESS_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cost         (cost),
    .kind         (kind),
    .address      (address),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .hit          (hit),
    .wrote_back   (wrote_back),
    .elapsed_time (elapsed_time)
  );

endmodule

[hdl/dmc_regs.sv]
// ----------------------------------------------------------------------------
// dmc_regs
// APB cost registers: four 16-bit cost values, write and read back.
// ----------------------------------------------------------------------------
module dmc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dmc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dmc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output dmc_pkg::dmc_cost_t           cost
);

  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cost.cache_read  <= dmc_pkg::RST_CACHE_READ;
      cost.cache_write <= dmc_pkg::RST_CACHE_WRITE;
      cost.mem_read    <= dmc_pkg::RST_MEM_READ;
      cost.mem_write   <= dmc_pkg::RST_MEM_WRITE;
    end else if (wr_en) begin
      case (reg_sel)
        dmc_pkg::REG_CACHE_READ:  cost.cache_read  <= pwdata[dmc_pkg::COST_W-1:0];
        dmc_pkg::REG_CACHE_WRITE: cost.cache_write <= pwdata[dmc_pkg::COST_W-1:0];
        dmc_pkg::REG_MEM_READ:    cost.mem_read    <= pwdata[dmc_pkg::COST_W-1:0];
        dmc_pkg::REG_MEM_WRITE:   cost.mem_write   <= pwdata[dmc_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      dmc_pkg::REG_CACHE_READ:  prdata[dmc_pkg::COST_W-1:0] = cost.cache_read;
      dmc_pkg::REG_CACHE_WRITE: prdata[dmc_pkg::COST_W-1:0] = cost.cache_write;
      dmc_pkg::REG_MEM_READ:    prdata[dmc_pkg::COST_W-1:0] = cost.mem_read;
      dmc_pkg::REG_MEM_WRITE:   prdata[dmc_pkg::COST_W-1:0] = cost.mem_write;
      default:                  prdata = '0;
    endcase
  end

endmodule

[hdl/dmc_ctrl.sv]
// ----------------------------------------------------------------------------
// dmc_ctrl
// Cache sequencer: clearing pass, lookup, write-back, fill and completion.
// ----------------------------------------------------------------------------
module dmc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmc_pkg::dmc_status_t st,
  output dmc_pkg::dmc_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_WB     = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (st.is_access && !st.hit) begin
          cmd.miss   = 1'b1;
          state_next = st.victim_dirty ? S_WB : S_FILL;
        end else if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WB: begin
        cmd.wb_step = 1'b1;
        if (st.step_last) state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (st.step_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/dmc_dp.sv]
// ----------------------------------------------------------------------------
// dmc_dp
// Cache datapath: tag, line and backing memories, flags, cost counter and
// result register.
// ----------------------------------------------------------------------------
module dmc_dp #(
  parameter int MEMORY_ADDRESS_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dmc_pkg::dmc_cmd_t            cmd,
  output dmc_pkg::dmc_status_t         st,
  input  dmc_pkg::dmc_cost_t           cost,
  input  logic [dmc_pkg::KIND_W-1:0]   kind,
  input  logic [dmc_pkg::ADDR_W-1:0]   address,
  input  logic [dmc_pkg::DATA_W-1:0]   write_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dmc_pkg::DATA_W-1:0]   read_data,
  output logic                         hit,
  output logic                         wrote_back,
  output logic [dmc_pkg::DATA_W-1:0]   elapsed_time
);

  localparam int BK_AW    = MEMORY_ADDRESS_BITS - 2;
  localparam int BK_DEPTH = 1 << BK_AW;
  localparam int WA_W     = dmc_pkg::TAG_W + dmc_pkg::INDEX_W + dmc_pkg::WORD_W;
  localparam logic [dmc_pkg::ADDR_W-1:0] ADDR_MASK =
    (MEMORY_ADDRESS_BITS >= dmc_pkg::ADDR_W) ? {dmc_pkg::ADDR_W{1'b1}} :
    dmc_pkg::ADDR_W'((32'd1 << MEMORY_ADDRESS_BITS) - 32'd1);

  // item
  logic [dmc_pkg::KIND_W-1:0]  kind_q;
  logic [dmc_pkg::TAG_W-1:0]   tag_q;
  logic [dmc_pkg::INDEX_W-1:0] idx_q;
  logic [dmc_pkg::WORD_W-1:0]  word_q;
  logic [dmc_pkg::DATA_W-1:0]  wdata_q;
  logic [dmc_pkg::ADDR_W-1:0]  addr_m;

  // flags and tags
  logic [dmc_pkg::LINES-1:0]   valid_q;
  logic [dmc_pkg::LINES-1:0]   dirty_q;
  logic [dmc_pkg::TAG_W-1:0]   tag_mem [dmc_pkg::LINES];
  logic [dmc_pkg::TAG_W-1:0]   tag_rd;

  // line words
  logic [dmc_pkg::DATA_W-1:0]  line_mem [dmc_pkg::LWORDS];
  logic [dmc_pkg::DATA_W-1:0]  line_rd;
  logic                        line_we;
  logic [dmc_pkg::INDEX_W+dmc_pkg::WORD_W-1:0] line_wa;
  logic [dmc_pkg::INDEX_W+dmc_pkg::WORD_W-1:0] line_ra;
  logic [dmc_pkg::DATA_W-1:0]  line_wd;

  // backing memory
  logic [dmc_pkg::DATA_W-1:0]  bk_mem [BK_DEPTH];
  logic [dmc_pkg::DATA_W-1:0]  bk_rd;
  logic                        bk_we;
  logic [BK_AW-1:0]            bk_wa;
  logic [BK_AW-1:0]            bk_ra;
  logic [dmc_pkg::DATA_W-1:0]  bk_wd;
  logic [WA_W-1:0]             old_wa;
  logic [WA_W-1:0]             new_wa;
  logic [BK_AW+WA_W-1:0]       old_ext;
  logic [BK_AW+WA_W-1:0]       new_ext;
  logic [BK_AW-1:0]            clr_cnt;

  // sequencing
  logic [dmc_pkg::STEP_W-1:0]  step;
  logic [dmc_pkg::WORD_W-1:0]  step_prev;
  logic                        step_act;
  logic                        miss_q;
  logic                        wb_q;
  logic [dmc_pkg::DATA_W-1:0]  fill_word;
  logic                        is_wr;

  // cost
  logic [dmc_pkg::DATA_W-1:0]  counter;
  logic [dmc_pkg::DATA_W-1:0]  counter_next;

  assign addr_m    = address & ADDR_MASK;
  assign step_prev = step[dmc_pkg::WORD_W-1:0] - 4'd1;
  assign step_act  = (step != '0);
  assign is_wr     = (kind_q == dmc_pkg::KIND_WRITE);

  assign st.is_access    = (kind_q == dmc_pkg::KIND_READ) || is_wr;
  assign st.hit          = valid_q[idx_q] && (tag_rd == tag_q);
  assign st.victim_dirty = valid_q[idx_q] && dirty_q[idx_q];
  assign st.step_last    = (step == dmc_pkg::STEP_LAST);
  assign st.clear_last   = &clr_cnt;
  assign st.out_free     = !out_valid || out_ready;

  assign old_wa  = {tag_rd, idx_q, step_prev};
  assign new_wa  = {tag_q, idx_q, step[dmc_pkg::WORD_W-1:0]};
  assign old_ext = {{BK_AW{1'b0}}, old_wa};
  assign new_ext = {{BK_AW{1'b0}}, new_wa};

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q  <= kind;
      tag_q   <= addr_m[15:14];
      idx_q   <= addr_m[13:6];
      word_q  <= addr_m[5:2];
      wdata_q <= write_data;
      tag_rd  <= tag_mem[addr_m[13:6]];
    end
    if (cmd.miss) tag_mem[idx_q] <= tag_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      dirty_q <= '0;
    end else begin
      if (cmd.miss) begin
        valid_q[idx_q] <= 1'b1;
        dirty_q[idx_q] <= 1'b0;
      end
      if (cmd.finish && is_wr) dirty_q[idx_q] <= 1'b1;
    end
  end

  // line memory ports
  always_comb begin
    line_we = 1'b0;
    line_wa = {idx_q, word_q};
    line_wd = wdata_q;
    if (cmd.fill_step && step_act) begin
      line_we = 1'b1;
      line_wa = {idx_q, step_prev};
      line_wd = (is_wr && step_prev == word_q) ? wdata_q : bk_rd;
    end else if (cmd.finish && !miss_q && is_wr) begin
      line_we = 1'b1;
    end
    // outside the write-back copy the addressed word stays on line_rd
    if (cmd.accept) begin
      line_ra = addr_m[13:2];
    end else if (cmd.wb_step) begin
      line_ra = {idx_q, step[dmc_pkg::WORD_W-1:0]};
    end else begin
      line_ra = {idx_q, word_q};
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_wa] <= line_wd;
    line_rd <= line_mem[line_ra];
  end

  // backing memory ports
  always_comb begin
    bk_we = 1'b0;
    bk_wa = clr_cnt;
    bk_wd = '0;
    if (cmd.clear_step) begin
      bk_we = 1'b1;
    end else if (cmd.wb_step && step_act) begin
      bk_we = 1'b1;
      bk_wa = old_ext[BK_AW-1:0];
      bk_wd = line_rd;
    end
    bk_ra = new_ext[BK_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
    bk_rd <= bk_mem[bk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // block copy sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      miss_q <= 1'b0;
      wb_q   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        miss_q <= 1'b0;
        wb_q   <= 1'b0;
      end
      if (cmd.miss) begin
        miss_q <= 1'b1;
        wb_q   <= st.victim_dirty;
        step   <= '0;
      end
      if (cmd.wb_step || cmd.fill_step) begin
        step <= st.step_last ? '0 : step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step && step_act && step_prev == word_q) fill_word <= bk_rd;
  end

  // cost counter
  always_comb begin
    counter_next = counter;
    if (cmd.miss) begin
      counter_next = counter + {16'd0, cost.mem_read};
    end else if (cmd.wb_step && st.step_last) begin
      counter_next = counter + {16'd0, cost.mem_write};
    end else if (cmd.finish) begin
      case (kind_q)
        dmc_pkg::KIND_READ:  counter_next = counter + {16'd0, cost.cache_read};
        dmc_pkg::KIND_WRITE: counter_next = counter + {16'd0, cost.cache_write};
        dmc_pkg::KIND_CLEAR: counter_next = '0;
        default:             counter_next = counter;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else begin
      counter <= counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (kind_q == dmc_pkg::KIND_READ) begin
        read_data <= miss_q ? fill_word : line_rd;
      end else begin
        read_data <= '0;
      end
      hit          <= st.is_access && !miss_q;
      wrote_back   <= st.is_access && wb_q;
      elapsed_time <= counter_next;
    end
  end

endmodule

[tb/direct_mapped_writeback_cache_top_test.sv]
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_top_test
// Self-checking bench for the direct-mapped write-back cache. A queue-fed
// driver sends read, write, clear and unused-kind transactions in bursts; a
// monitor stalls the result channel and compares each result with a cycle-free
// cache and backing memory model. Cost registers are programmed over APB
// between phases, including all-zero, all-ones and a back-to-back hit run at
// maximum costs.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_top_test;
  import dmc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int BACKING_WORDS = 1 << (ADDR_W - 2);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } access_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              was_hit;
    logic              wb;
    logic [DATA_W-1:0] elapsed;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = '0;
  logic [ADDR_W-1:0]   address = '0;
  logic [DATA_W-1:0]   write_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   read_data;
  logic                hit;
  logic                wrote_back;
  logic [DATA_W-1:0]   elapsed_time;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  direct_mapped_writeback_cache_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .address(address), .write_data(write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .hit(hit), .wrote_back(wrote_back),
    .elapsed_time(elapsed_time),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // cache model state
  dmc_cost_t         cost_cfg = '{RST_CACHE_READ, RST_CACHE_WRITE, RST_MEM_READ, RST_MEM_WRITE};
  bit [TAG_W-1:0]    line_tag [LINES];
  bit                line_valid [LINES];
  bit                line_dirty [LINES];
  bit [DATA_W-1:0]   line_data [LWORDS];
  bit [DATA_W-1:0]   backing_mem [BACKING_WORDS];
  logic [DATA_W-1:0] elapsed_model = '0;

  access_t  access_queue[$];
  outcome_t expected_results[$];
  access_t  drive_item;
  logic [INDEX_W-1:0] hot_lines [6];

  int unsigned gap_max = 0;
  int unsigned stall_mode = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_tick = 0;
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned writebacks_seen = 0;
  int unsigned clears_sent = 0;
  int unsigned unused_sent = 0;
  int unsigned settings_used = 1;

  function automatic outcome_t cache_access(input access_t a);
    outcome_t r;
    logic [TAG_W-1:0]   tg;
    logic [INDEX_W-1:0] ln;
    logic [WORD_W-1:0]  wd;
    int unsigned        new_base;
    int unsigned        old_base;
    int unsigned        lbase;
    r = '0;
    if (a.kind == KIND_CLEAR) begin
      elapsed_model = '0;
    end else if (a.kind == KIND_READ || a.kind == KIND_WRITE) begin
      tg = a.addr[ADDR_W-1 -: TAG_W];
      ln = a.addr[2+WORD_W +: INDEX_W];
      wd = a.addr[2 +: WORD_W];
      lbase = {ln, 4'b0000};
      if (line_valid[ln] && line_tag[ln] == tg) begin
        r.was_hit = 1'b1;
      end else begin
        new_base = {tg, ln, 4'b0000};
        elapsed_model = elapsed_model + DATA_W'(cost_cfg.mem_read);
        if (line_valid[ln] && line_dirty[ln]) begin
          old_base = {line_tag[ln], ln, 4'b0000};
          for (int i = 0; i < 16; i++) backing_mem[old_base + i] = line_data[lbase + i];
          elapsed_model = elapsed_model + DATA_W'(cost_cfg.mem_write);
          r.wb = 1'b1;
        end
        for (int i = 0; i < 16; i++) line_data[lbase + i] = backing_mem[new_base + i];
        line_valid[ln] = 1'b1;
        line_tag[ln] = tg;
        line_dirty[ln] = 1'b0;
      end
      if (a.kind == KIND_READ) begin
        r.rdata = line_data[lbase + wd];
        elapsed_model = elapsed_model + DATA_W'(cost_cfg.cache_read);
      end else begin
        line_data[lbase + wd] = a.wdata;
        elapsed_model = elapsed_model + DATA_W'(cost_cfg.cache_write);
        line_dirty[ln] = 1'b1;
      end
    end
    r.elapsed = elapsed_model;
    return r;
  endfunction

  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) a.kind = KIND_READ;
    else if (pick < 85) a.kind = KIND_WRITE;
    else if (pick < 93) a.kind = KIND_CLEAR;
    else a.kind = KIND_UNUSED;
    a.wdata = $urandom;
    if ($urandom_range(0, 9) < 7)
      a.addr = {TAG_W'($urandom), hot_lines[$urandom_range(0, 5)], 6'($urandom)};
    else
      a.addr = ADDR_W'($urandom);
    return a;
  endfunction

  task automatic queue_access(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
    access_queue.push_back('{k, a, d});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (access_queue.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // upper pwdata bits are random and must be ignored
  task automatic program_costs(input dmc_cost_t c);
    logic [1:0]        regs [4];
    logic [COST_W-1:0] vals [4];
    regs = '{REG_CACHE_READ, REG_CACHE_WRITE, REG_MEM_READ, REG_MEM_WRITE};
    vals = '{c.cache_read, c.cache_write, c.mem_read, c.mem_write};
    for (int r = 0; r < 4; r++) begin
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[r], 2'b00};
      pwdata  <= {16'($urandom), vals[r]};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    cost_cfg = c;
    settings_used++;
  endtask

  task automatic random_phase(input dmc_cost_t c, input int unsigned gaps,
                              input int unsigned stalls, input int unsigned count);
    program_costs(c);
    gap_max = gaps;
    stall_mode = stalls;
    foreach (hot_lines[i]) hot_lines[i] = INDEX_W'($urandom);
    repeat (count) access_queue.push_back(random_access());
    drain();
  endtask

  function automatic dmc_cost_t random_costs();
    dmc_cost_t c;
    c.cache_read  = COST_W'($urandom);
    c.cache_write = COST_W'($urandom);
    c.mem_read    = COST_W'($urandom);
    c.mem_write   = COST_W'($urandom);
    return c;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(cache_access(drive_item));
        if (drive_item.kind == KIND_CLEAR) clears_sent++;
        if (drive_item.kind == KIND_UNUSED) unused_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (access_queue.size() != 0) begin
          drive_item = access_queue.pop_front();
          kind       <= drive_item.kind;
          address    <= drive_item.addr;
          write_data <= drive_item.wdata;
          in_valid   <= 1'b1;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0 && gap_max != 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result checking and output stalls
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (errors < 40)
            $display("%0t: result with no transaction outstanding, read_data %h elapsed %h",
                     $time, read_data, elapsed_time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.rdata, read_data);
          check_field("hit", DATA_W'(want.was_hit), DATA_W'(hit));
          check_field("wrote_back", DATA_W'(want.wb), DATA_W'(wrote_back));
          check_field("elapsed_time", want.elapsed, elapsed_time);
          results_checked++;
          if (want.was_hit) hits_seen++;
          if (want.wb) writebacks_seen++;
        end
      end
      stall_tick++;
      case (stall_mode)
        1: begin
          out_ready <= ($urandom_range(0, 2) != 0);
        end
        2: begin
          out_ready <= (stall_tick % 7) < 4;
        end
        default: begin
          out_ready <= 1'b1;
        end
      endcase
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] wrap_addr;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset costs; directed corner transactions
    gap_max = 2;
    stall_mode = 1;
    queue_access(KIND_READ,   16'h0000, 32'h1234_5678);
    queue_access(KIND_WRITE,  16'h0004, 32'hFFFF_FFFF);
    queue_access(KIND_READ,   16'h0007, 32'h0000_0000);
    queue_access(KIND_WRITE,  16'hFFFF, 32'h0000_0000);
    queue_access(KIND_WRITE,  16'hFFFA, 32'hA5A5_5A5A);
    queue_access(KIND_READ,   16'h3FFC, 32'hFFFF_FFFF);
    queue_access(KIND_READ,   16'hFFF9, 32'h0000_0000);
    queue_access(KIND_READ,   16'hFFFC, 32'h0000_0000);
    queue_access(KIND_CLEAR,  16'h0000, 32'h0000_0000);
    queue_access(KIND_UNUSED, 16'h1234, 32'hDEAD_BEEF);
    queue_access(KIND_WRITE,  16'h4002, 32'h0F0F_0F0F);
    queue_access(KIND_READ,   16'h0005, 32'h0000_0000);
    queue_access(KIND_READ,   16'h4000, 32'h0000_0000);
    queue_access(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    queue_access(KIND_WRITE,  16'h8000, 32'h8000_0001);
    queue_access(KIND_WRITE,  16'hC03F, 32'h7FFF_FFFE);
    queue_access(KIND_READ,   16'h8003, 32'h0000_0000);
    queue_access(KIND_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
    queue_access(KIND_READ,   16'hC03C, 32'h0000_0000);
    drain();

    random_phase(random_costs(), 4, 1, 140);
    random_phase('0, 0, 2, 140);
    random_phase('1, 6, 1, 140);

    // all costs at maximum, back-to-back hits on one line
    gap_max = 0;
    stall_mode = 0;
    wrap_addr = ADDR_W'($urandom);
    queue_access(KIND_CLEAR, wrap_addr, 32'h0);
    queue_access(KIND_WRITE, wrap_addr, $urandom);
    repeat (40)
      queue_access(KIND_READ, {wrap_addr[ADDR_W-1:6], 6'($urandom)}, $urandom);
    drain();

    random_phase(random_costs(), 3, 2, 140);

    repeat (60) @(negedge clk);
    $display("Checked %0d results under %0d cost settings.",
             results_checked, settings_used);
    $display("Saw %0d hits, %0d write-backs, %0d counter clears, %0d unused-kind transactions.",
             hits_seen, writebacks_seen, clears_sent, unused_sent);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
